/* design/color_keyed_layer_compositor_assert.svh */
// assertion macros for the color keyed layer compositor
// sampled on clk, disabled while rst_n is low
`ifndef COLOR_KEYED_LAYER_COMPOSITOR_ASSERT_SVH
`define COLOR_KEYED_LAYER_COMPOSITOR_ASSERT_SVH

// same-cycle implication
`define CKL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CKL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/ckl_pkg.sv */
// shared constants and types for the color keyed layer compositor
// no dependencies
package ckl_pkg;

  localparam int LAYERS_DEF      = 4;
  localparam int LAYER_MAX_W_DEF = 64;
  localparam int LAYER_MAX_H_DEF = 64;
  localparam int SCREEN_LIMIT    = 4096;

  // command codes
  localparam logic [1:0] CMD_GEOM  = 2'd0;
  localparam logic [1:0] CMD_PIXEL = 2'd1;
  localparam logic [1:0] CMD_COMP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_TOP_LAYER = 2'd0;
  localparam logic [1:0] CFG_SCREEN_W  = 2'd1;
  localparam logic [1:0] CFG_SCREEN_H  = 2'd2;

  localparam logic signed [2:0] TOP_LAYER_RST = -3'sd1;
  localparam logic [12:0]       SCREEN_W_RST  = 13'd320;
  localparam logic [12:0]       SCREEN_H_RST  = 13'd200;

  typedef logic signed [15:0] coord_t;
  typedef logic [6:0]         size_t;
  typedef logic [7:0]         color_t;
  typedef logic [5:0]         local_t;
  typedef logic [11:0]        scr_t;
  typedef logic [12:0]        cfg_data_t;
  typedef logic [23:0]        vram_t;

endpackage

/* design/ckl_channels.sv */
// valid/ready channel interfaces: input items, result items, configuration writes
// depends on ckl_pkg
interface ckl_in_if;
  import ckl_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [1:0] layer;
  coord_t     origin_x;
  coord_t     origin_y;
  size_t      layer_width;
  size_t      layer_height;
  color_t     key_color;
  local_t     local_x;
  local_t     local_y;
  color_t     pixel_color;
  coord_t     screen_x;
  coord_t     screen_y;

  modport source (output valid, cmd, layer, origin_x, origin_y, layer_width, layer_height,
                  key_color, local_x, local_y, pixel_color, screen_x, screen_y,
                  input ready);
  modport sink (input valid, cmd, layer, origin_x, origin_y, layer_width, layer_height,
                key_color, local_x, local_y, pixel_color, screen_x, screen_y,
                output ready);
endinterface

interface ckl_out_if;
  import ckl_pkg::*;
  logic   valid;
  logic   ready;
  scr_t   out_x;
  scr_t   out_y;
  color_t out_color;
  vram_t  vram_index;

  modport source (output valid, out_x, out_y, out_color, vram_index, input ready);
  modport sink (input valid, out_x, out_y, out_color, vram_index, output ready);
endinterface

interface ckl_cfg_if;
  import ckl_pkg::*;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  cfg_data_t  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* design/ckl_ram.sv */
// generic single-write, single-read RAM with registered read data
// no dependencies
module ckl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while re is low
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* design/color_keyed_layer_compositor.sv */
// color keyed layer compositor top level: layer tables, pixel store, layer walk
// depends on ckl_pkg, ckl_channels, ckl_ram, color_keyed_layer_compositor_assert.svh
//
//  channel  dir  modport  carries
//  in_ch    in   sink     geometry load, pixel write or composite request
//  out_ch   out  source   composited pixel: position, color, frame-buffer index
//  cfg_ch   in   sink     register write (top layer, screen width, screen height)
//
// loads are accepted back to back while no composite is being walked
// a composite walks the layers from the top down, a walk step per layer and a pixel check
// when the layer covers the pixel; a clipped composite request is accepted and dropped
// a finished result waits in the output register; the walk stalls only if a second
// result is ready while the first is still untaken
// reset clears state, output valid, config and layer geometry; the pixel store is not cleared
module color_keyed_layer_compositor #(
  parameter int LAYERS      = ckl_pkg::LAYERS_DEF,
  parameter int LAYER_MAX_W = ckl_pkg::LAYER_MAX_W_DEF,
  parameter int LAYER_MAX_H = ckl_pkg::LAYER_MAX_H_DEF
) (
  input logic       clk,
  input logic       rst_n,
  ckl_in_if.sink    in_ch,
  ckl_out_if.source out_ch,
  ckl_cfg_if.sink   cfg_ch
);
  import ckl_pkg::*;

  `include "color_keyed_layer_compositor_assert.svh"

  localparam int HW    = (LAYERS > 1) ? $clog2(LAYERS) : 1;
  localparam int PLANE = LAYER_MAX_W * LAYER_MAX_H;
  localparam int DEPTH = LAYERS * PLANE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_CHECK} state_t;

  // configuration registers
  logic signed [2:0] top_layer_r;
  cfg_data_t         scr_w_r;
  cfg_data_t         scr_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_layer_r <= TOP_LAYER_RST;
      scr_w_r     <= SCREEN_W_RST;
      scr_h_r     <= SCREEN_H_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_TOP_LAYER: top_layer_r <= cfg_ch.data[2:0];
        CFG_SCREEN_W:  scr_w_r     <= cfg_ch.data;
        CFG_SCREEN_H:  scr_h_r     <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  logic [12:0] sw_eff;
  logic [12:0] sh_eff;
  assign sw_eff = (int'(scr_w_r) > SCREEN_LIMIT) ? 13'(SCREEN_LIMIT) : scr_w_r;
  assign sh_eff = (int'(scr_h_r) > SCREEN_LIMIT) ? 13'(SCREEN_LIMIT) : scr_h_r;

  // layer geometry tables
  coord_t ox_r  [LAYERS];
  coord_t oy_r  [LAYERS];
  size_t  w_r   [LAYERS];
  size_t  ht_r  [LAYERS];
  color_t key_r [LAYERS];

  state_t          state_r;
  logic            in_acc;
  logic [HW-1:0]   lyr_idx;
  logic            lyr_ok;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign lyr_idx     = HW'(in_ch.layer);
  assign lyr_ok      = int'(in_ch.layer) < LAYERS;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAYERS; i++) begin
        ox_r[i]  <= '0;
        oy_r[i]  <= '0;
        w_r[i]   <= '0;
        ht_r[i]  <= '0;
        key_r[i] <= '0;
      end
    end else if (in_acc && in_ch.cmd == CMD_GEOM && lyr_ok) begin
      ox_r[lyr_idx]  <= in_ch.origin_x;
      oy_r[lyr_idx]  <= in_ch.origin_y;
      w_r[lyr_idx]   <= in_ch.layer_width;
      ht_r[lyr_idx]  <= in_ch.layer_height;
      key_r[lyr_idx] <= in_ch.key_color;
    end
  end

  // pixel store
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  color_t        ram_rdata;

  assign ram_we = in_acc && in_ch.cmd == CMD_PIXEL && lyr_ok &&
                  int'(in_ch.local_x) < LAYER_MAX_W && int'(in_ch.local_y) < LAYER_MAX_H;
  assign ram_waddr = AW'(int'(lyr_idx) * PLANE + int'(in_ch.local_y) * LAYER_MAX_W +
                         int'(in_ch.local_x));

  ckl_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_pix_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_ch.pixel_color),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // composite request qualification
  int  top_eff;
  logic comp_go;

  assign top_eff = (int'(top_layer_r[1:0]) > LAYERS - 1) ? LAYERS - 1
                                                         : int'(top_layer_r[1:0]);
  assign comp_go = !top_layer_r[2] && !in_ch.screen_x[15] && !in_ch.screen_y[15] &&
                   ({1'b0, in_ch.screen_x[14:0]} < {3'b0, sw_eff}) &&
                   ({1'b0, in_ch.screen_y[14:0]} < {3'b0, sh_eff}) &&
                   (int'(in_ch.layer) <= top_eff);

  // walk registers
  logic [HW-1:0] h_r;
  logic [1:0]    lo_r;
  scr_t          sx_r;
  scr_t          sy_r;
  vram_t         idx_r;

  logic signed [16:0] lx;
  logic signed [16:0] ly;
  size_t              w_eff;
  size_t              ht_eff;
  logic               covers;
  logic               at_low;

  assign lx     = $signed({5'b0, sx_r}) - $signed({ox_r[h_r][15], ox_r[h_r]});
  assign ly     = $signed({5'b0, sy_r}) - $signed({oy_r[h_r][15], oy_r[h_r]});
  assign w_eff  = (int'(w_r[h_r]) > LAYER_MAX_W) ? 7'(LAYER_MAX_W) : w_r[h_r];
  assign ht_eff = (int'(ht_r[h_r]) > LAYER_MAX_H) ? 7'(LAYER_MAX_H) : ht_r[h_r];
  assign covers = !lx[16] && !ly[16] && (lx < $signed({10'b0, w_eff})) &&
                  (ly < $signed({10'b0, ht_eff}));
  assign at_low = (int'(h_r) == int'(lo_r));

  assign ram_re    = (state_r == ST_WALK) && covers;
  assign ram_raddr = AW'(int'(h_r) * PLANE + int'(ly) * LAYER_MAX_W + int'(lx));

  // output register
  logic   out_valid_r;
  scr_t   out_x_r;
  scr_t   out_y_r;
  color_t out_color_r;
  vram_t  out_idx_r;
  logic   out_free;

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_ch.cmd == CMD_COMP && comp_go) begin
            h_r     <= HW'(top_eff);
            lo_r    <= in_ch.layer;
            sx_r    <= in_ch.screen_x[11:0];
            sy_r    <= in_ch.screen_y[11:0];
            state_r <= ST_WALK;
          end
        end
        ST_WALK: begin
          idx_r <= 24'(int'(sy_r) * int'(sw_eff) + int'(sx_r));
          if (covers) begin
            state_r <= ST_CHECK;
          end else if (at_low) begin
            state_r <= ST_IDLE;
          end else begin
            h_r <= h_r - 1'b1;
          end
        end
        ST_CHECK: begin
          if (ram_rdata != key_r[h_r]) begin
            // opaque hit: wait here if the previous result is still untaken
            if (out_free) begin
              out_valid_r <= 1'b1;
              out_x_r     <= sx_r;
              out_y_r     <= sy_r;
              out_color_r <= ram_rdata;
              out_idx_r   <= idx_r;
              state_r     <= ST_IDLE;
            end
          end else if (at_low) begin
            state_r <= ST_IDLE;
          end else begin
            h_r     <= h_r - 1'b1;
            state_r <= ST_WALK;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_x      = out_x_r;
  assign out_ch.out_y      = out_y_r;
  assign out_ch.out_color  = out_color_r;
  assign out_ch.vram_index = out_idx_r;

  `CKL_ASSERT_IMPL(a_result_from_check, $rose(out_valid_r), $past(state_r) == ST_CHECK,
                   "result appeared without a pixel check")
  `CKL_ASSERT_IMPL(a_walk_above_low, state_r != ST_IDLE,
                   int'(h_r) >= int'(lo_r) && int'(h_r) < LAYERS,
                   "layer walk left its range")
  `CKL_ASSERT_IMPL(a_ram_one_access, ram_we, !ram_re,
                   "pixel store written and read in one cycle")
  `CKL_ASSERT_NEXT(a_check_after_read, ram_re, state_r == ST_CHECK,
                   "pixel read not followed by a check")

endmodule

/* tb/sv/testbench.sv */
// self-checking testbench for color_keyed_layer_compositor: drives layer loads, pixel writes
// and composite requests, predicts each composited pixel and checks it on the result channel
// depends on ckl_pkg, ckl_channels and the compositor rtl
module testbench;
  import ckl_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int STORE_DEPTH = LAYERS_DEF * LAYER_MAX_W_DEF * LAYER_MAX_H_DEF;
  localparam int DRAIN_WAIT  = 20;
  localparam int RESULT_WAIT = 5000;
  localparam int HOLD_OFF    = 400;

  localparam logic [1:0] CMD_NONE   = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0] cmd;
    logic [1:0] layer;
    coord_t     origin_x;
    coord_t     origin_y;
    size_t      layer_width;
    size_t      layer_height;
    color_t     key_color;
    local_t     local_x;
    local_t     local_y;
    color_t     pixel_color;
    coord_t     screen_x;
    coord_t     screen_y;
  } layer_req_t;

  typedef struct packed {
    scr_t   x;
    scr_t   y;
    color_t color;
    vram_t  index;
  } screen_pixel_t;

  logic clk;
  logic rst_n;

  ckl_in_if  in_ch ();
  ckl_out_if out_ch ();
  ckl_cfg_if cfg_ch ();

  color_keyed_layer_compositor uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // request currently offered on the input channel
  layer_req_t offer;
  assign in_ch.cmd          = offer.cmd;
  assign in_ch.layer        = offer.layer;
  assign in_ch.origin_x     = offer.origin_x;
  assign in_ch.origin_y     = offer.origin_y;
  assign in_ch.layer_width  = offer.layer_width;
  assign in_ch.layer_height = offer.layer_height;
  assign in_ch.key_color    = offer.key_color;
  assign in_ch.local_x      = offer.local_x;
  assign in_ch.local_y      = offer.local_y;
  assign in_ch.pixel_color  = offer.pixel_color;
  assign in_ch.screen_x     = offer.screen_x;
  assign in_ch.screen_y     = offer.screen_y;

  // compositor state as seen at the channel boundary
  logic signed [2:0] top_reg;
  cfg_data_t         scr_w_reg;
  cfg_data_t         scr_h_reg;
  int                geo_ox [LAYERS_DEF];
  int                geo_oy [LAYERS_DEF];
  int                geo_w [LAYERS_DEF];
  int                geo_h [LAYERS_DEF];
  color_t            geo_key [LAYERS_DEF];
  color_t            layer_store [STORE_DEPTH];

  // stimulus-side view of geometry, used to keep reads inside written pixels
  int     plan_ox [LAYERS_DEF];
  int     plan_oy [LAYERS_DEF];
  int     plan_w [LAYERS_DEF];
  int     plan_h [LAYERS_DEF];
  color_t plan_key [LAYERS_DEF];
  int     plan_sw;
  int     plan_sh;
  bit     written [STORE_DEPTH];

  layer_req_t    pending_reqs[$];
  screen_pixel_t expected_pixels[$];

  logic in_taken;
  int   send_gap;
  int   stall_left;
  bit   pressure_req;
  bit   calm;

  int mismatch_count;
  int requests_seen;
  int composites_seen;
  int pixels_checked;
  int setting_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int store_addr(input int h, input int lx, input int ly);
    return (h * LAYER_MAX_H_DEF + ly) * LAYER_MAX_W_DEF + lx;
  endfunction

  // layer size saturates at the pixel store dimensions
  function automatic bit covers(input int ox, input int oy, input int w, input int hh,
                                input int sx, input int sy, output int lx, output int ly);
    lx = sx - ox;
    ly = sy - oy;
    if (w > LAYER_MAX_W_DEF) w = LAYER_MAX_W_DEF;
    if (hh > LAYER_MAX_H_DEF) hh = LAYER_MAX_H_DEF;
    return lx >= 0 && ly >= 0 && lx < w && ly < hh;
  endfunction

  // applies one accepted request; returns 1 when a screen pixel comes out
  function automatic bit render_request(input layer_req_t r, output screen_pixel_t px);
    int top, low, sx, sy, sw, sh, lx, ly, h;
    bit found;
    found = 1'b0;
    px = '0;
    case (r.cmd)
      CMD_GEOM: begin
        geo_ox[r.layer]  = $signed(r.origin_x);
        geo_oy[r.layer]  = $signed(r.origin_y);
        geo_w[r.layer]   = r.layer_width;
        geo_h[r.layer]   = r.layer_height;
        geo_key[r.layer] = r.key_color;
      end
      CMD_PIXEL: begin
        layer_store[store_addr(r.layer, r.local_x, r.local_y)] = r.pixel_color;
      end
      CMD_COMP: begin
        sx  = $signed(r.screen_x);
        sy  = $signed(r.screen_y);
        sw  = (scr_w_reg > SCREEN_LIMIT) ? SCREEN_LIMIT : int'(scr_w_reg);
        sh  = (scr_h_reg > SCREEN_LIMIT) ? SCREEN_LIMIT : int'(scr_h_reg);
        top = top_reg;
        if (top > LAYERS_DEF - 1) top = LAYERS_DEF - 1;
        low = r.layer;
        if (top >= 0 && sx >= 0 && sy >= 0 && sx < sw && sy < sh) begin
          // walk down from the top; a key-colored pixel lets lower layers show through
          for (h = top; h >= low && !found; h--) begin
            if (covers(geo_ox[h], geo_oy[h], geo_w[h], geo_h[h], sx, sy, lx, ly) &&
                layer_store[store_addr(h, lx, ly)] != geo_key[h]) begin
              found    = 1'b1;
              px.color = layer_store[store_addr(h, lx, ly)];
            end
          end
        end
        if (found) begin
          px.x     = scr_t'(sx);
          px.y     = scr_t'(sy);
          px.index = vram_t'(sy * sw + sx);
        end
      end
      default: ;
    endcase
    return found;
  endfunction

  function automatic layer_req_t any_fields();
    logic [127:0] bits;
    bits = {$urandom, $urandom, $urandom, $urandom};
    return bits[$bits(layer_req_t)-1:0];
  endfunction

  function automatic layer_req_t make_geom(input int h, input int ox, input int oy,
                                           input int w, input int hh, input color_t key);
    layer_req_t r;
    r              = any_fields();
    r.cmd          = CMD_GEOM;
    r.layer        = 2'(h);
    r.origin_x     = coord_t'(ox);
    r.origin_y     = coord_t'(oy);
    r.layer_width  = size_t'(w);
    r.layer_height = size_t'(hh);
    r.key_color    = key;
    return r;
  endfunction

  function automatic layer_req_t make_pixel(input int h, input int lx, input int ly,
                                            input color_t c);
    layer_req_t r;
    r             = any_fields();
    r.cmd         = CMD_PIXEL;
    r.layer       = 2'(h);
    r.local_x     = local_t'(lx);
    r.local_y     = local_t'(ly);
    r.pixel_color = c;
    return r;
  endfunction

  function automatic layer_req_t make_comp(input int low, input int sx, input int sy);
    layer_req_t r;
    r          = any_fields();
    r.cmd      = CMD_COMP;
    r.layer    = 2'(low);
    r.screen_x = coord_t'(sx);
    r.screen_y = coord_t'(sy);
    return r;
  endfunction

  function automatic layer_req_t make_idle();
    layer_req_t r;
    r     = any_fields();
    r.cmd = CMD_NONE;
    return r;
  endfunction

  // key colors come up often so that transparency is exercised
  function automatic color_t pick_color(input int h);
    if ($urandom_range(0, 9) < 3) return plan_key[h];
    return color_t'($urandom);
  endfunction

  function automatic int pick_size();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return 0;
    if (sel < 3) return $urandom_range(LAYER_MAX_W_DEF + 1, 127);
    return $urandom_range(1, LAYER_MAX_W_DEF);
  endfunction

  // queues a request; a composite first gets any covering pixel it could read written
  task automatic queue_request(input layer_req_t r);
    int h, lx, ly;
    case (r.cmd)
      CMD_GEOM: begin
        plan_ox[r.layer]  = $signed(r.origin_x);
        plan_oy[r.layer]  = $signed(r.origin_y);
        plan_w[r.layer]   = r.layer_width;
        plan_h[r.layer]   = r.layer_height;
        plan_key[r.layer] = r.key_color;
      end
      CMD_PIXEL: written[store_addr(r.layer, r.local_x, r.local_y)] = 1'b1;
      CMD_COMP: begin
        for (h = 0; h < LAYERS_DEF; h++) begin
          if (covers(plan_ox[h], plan_oy[h], plan_w[h], plan_h[h], $signed(r.screen_x),
                     $signed(r.screen_y), lx, ly) && !written[store_addr(h, lx, ly)]) begin
            written[store_addr(h, lx, ly)] = 1'b1;
            pending_reqs.push_back(make_pixel(h, lx, ly, pick_color(h)));
          end
        end
      end
      default: ;
    endcase
    pending_reqs.push_back(r);
  endtask

  // mostly composites aimed at layer rectangles, mixed with loads and noise
  task automatic plan_random(input int count);
    int k, pick, h, low, sel, cw, ch, ox, oy, sx, sy, lx, ly;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      h    = $urandom_range(0, LAYERS_DEF - 1);
      cw   = (plan_w[h] > LAYER_MAX_W_DEF) ? LAYER_MAX_W_DEF : plan_w[h];
      ch   = (plan_h[h] > LAYER_MAX_H_DEF) ? LAYER_MAX_H_DEF : plan_h[h];
      if (pick < 8) begin
        if ($urandom_range(0, 9) == 0) begin
          ox = $urandom;
          oy = $urandom;
        end else begin
          ox = int'($urandom_range(0, plan_sw + 40)) - 40;
          oy = int'($urandom_range(0, plan_sh + 40)) - 40;
        end
        queue_request(make_geom(h, ox, oy, pick_size(), pick_size(), color_t'($urandom)));
      end else if (pick < 30) begin
        lx = $urandom_range(0, LAYER_MAX_W_DEF - 1);
        ly = $urandom_range(0, LAYER_MAX_H_DEF - 1);
        if (cw > 0 && ch > 0 && $urandom_range(0, 3) != 0) begin
          lx = $urandom_range(0, cw - 1);
          ly = $urandom_range(0, ch - 1);
        end
        queue_request(make_pixel(h, lx, ly, pick_color(h)));
      end else if (pick < 90) begin
        low = ($urandom_range(0, 1) == 0) ? 0 : int'($urandom_range(0, LAYERS_DEF - 1));
        sel = $urandom_range(0, 7);
        if (sel == 0) begin
          sx = $urandom;
          sy = $urandom;
        end else if (sel == 1) begin
          sx = plan_sw - int'($urandom_range(0, 1));
          sy = plan_sh - int'($urandom_range(0, 1));
        end else begin
          sx = plan_ox[h] + int'($urandom_range(0, cw + 3)) - 2;
          sy = plan_oy[h] + int'($urandom_range(0, ch + 3)) - 2;
        end
        queue_request(make_comp(low, sx, sy));
      end else if (pick < 94) begin
        queue_request(make_idle());
      end else begin
        queue_request(any_fields());
      end
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input cfg_data_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic apply_setting(input int top, input int w, input int hh);
    cfg_data_t d;
    d      = cfg_data_t'($urandom);
    d[2:0] = 3'(top);
    write_reg(CFG_TOP_LAYER, d);
    write_reg(CFG_SCREEN_W, cfg_data_t'(w));
    write_reg(CFG_SCREEN_H, cfg_data_t'(hh));
    plan_sw = (w > SCREEN_LIMIT) ? SCREEN_LIMIT : w;
    plan_sh = (hh > SCREEN_LIMIT) ? SCREEN_LIMIT : hh;
    setting_count++;
  endtask

  // block is idle once every request is in, every pixel is out and the walk has had time
  task automatic settle();
    int waited;
    screen_pixel_t lost;
    while (pending_reqs.size() != 0 || in_ch.valid) @(posedge clk);
    waited = 0;
    while (expected_pixels.size() != 0 && waited < RESULT_WAIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_WAIT) @(posedge clk);
    while (expected_pixels.size() != 0) begin
      lost = expected_pixels.pop_front();
      $display("%0t: missing pixel, expected x=%0d y=%0d color=%0d index=%0d, got none",
               $time, lost.x, lost.y, lost.color, lost.index);
      mismatch_count++;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // input driver: holds a request until its transaction completes
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 9);
        in_ch.valid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        offer <= pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result receiver: random stall bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (pressure_req) begin
      pressure_req = 1'b0;
      stall_left   = HOLD_OFF - 1;
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : observe
    screen_pixel_t got, want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_TOP_LAYER: top_reg   = cfg_ch.data[2:0];
          CFG_SCREEN_W:  scr_w_reg = cfg_ch.data;
          CFG_SCREEN_H:  scr_h_reg = cfg_ch.data;
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.out_x, out_ch.out_y, out_ch.out_color, out_ch.vram_index};
        if (expected_pixels.size() == 0) begin
          $display("%0t: expected no pixel, got x=%0d y=%0d color=%0d index=%0d",
                   $time, got.x, got.y, got.color, got.index);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("out_x", want.x, got.x);
          check_field("out_y", want.y, got.y);
          check_field("out_color", want.color, got.color);
          check_field("vram_index", want.index, got.index);
          pixels_checked++;
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        requests_seen++;
        if (offer.cmd == CMD_COMP) composites_seen++;
        if (render_request(offer, want)) expected_pixels.push_back(want);
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timed out after %0d cycles", CYCLE_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n        = 1'b0;
    offer        = '0;
    in_ch.valid  = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_TOP_LAYER;
    cfg_ch.data  = '0;
    in_taken     = 1'b0;
    send_gap     = 0;
    stall_left   = 0;
    pressure_req = 1'b0;
    calm         = 1'b0;
    top_reg      = TOP_LAYER_RST;
    scr_w_reg    = SCREEN_W_RST;
    scr_h_reg    = SCREEN_H_RST;
    plan_sw      = SCREEN_W_RST;
    plan_sh      = SCREEN_H_RST;
    for (int h = 0; h < LAYERS_DEF; h++) begin
      geo_ox[h]   = 0;
      geo_oy[h]   = 0;
      geo_w[h]    = 0;
      geo_h[h]    = 0;
      geo_key[h]  = '0;
      plan_ox[h]  = 0;
      plan_oy[h]  = 0;
      plan_w[h]   = 0;
      plan_h[h]   = 0;
      plan_key[h] = '0;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: no layer shown, so nothing comes out
    queue_request(make_geom(0, 0, 0, 64, 64, 8'h00));
    queue_request(make_comp(0, 10, 10));
    settle();

    apply_setting(3, 320, 200);
    queue_request(make_geom(0, 0, 0, 64, 64, 8'h00));
    queue_request(make_geom(1, 300, 190, 127, 127, 8'hFF));
    queue_request(make_geom(2, 0, 0, 32, 32, 8'h5A));
    queue_request(make_geom(3, -32768, 32767, 0, 0, 8'hAA));
    queue_request(make_pixel(0, 0, 0, 8'hFF));
    queue_request(make_pixel(0, 63, 63, 8'h00));
    queue_request(make_pixel(1, 19, 9, 8'h00));
    queue_request(make_pixel(1, 0, 0, 8'hFF));
    queue_request(make_pixel(0, 5, 5, 8'h3C));
    queue_request(make_pixel(2, 5, 5, 8'h5A));
    queue_request(make_pixel(2, 6, 5, 8'h77));
    queue_request(make_comp(0, 0, 0));
    queue_request(make_comp(0, 319, 199));
    queue_request(make_comp(0, 320, 0));
    queue_request(make_comp(0, -1, 0));
    queue_request(make_comp(0, -32768, 32767));
    queue_request(make_comp(0, 32767, -32768));
    queue_request(make_comp(0, 63, 63));
    queue_request(make_comp(0, 5, 5));
    queue_request(make_comp(0, 6, 5));
    queue_request(make_comp(3, 6, 5));
    queue_request(make_comp(1, 300, 190));
    queue_request(make_idle());
    plan_random(200);
    settle();

    // screen width above the limit, start layer often above the top
    apply_setting(1, 8191, 4096);
    plan_random(160);
    settle();

    // negative top and a zero-width screen: everything is dropped
    write_reg(CFG_UNUSED, cfg_data_t'($urandom));
    apply_setting(-4, 0, 1);
    plan_random(55);
    settle();

    apply_setting(2, 1, 8191);
    plan_random(100);
    settle();

    // full-size screen; receiver holds off so the compositor backs up
    apply_setting(3, 4096, 4096);
    plan_random(200);
    pressure_req = 1'b1;
    settle();

    apply_setting(3, 640, 480);
    calm = 1'b1;
    plan_random(300);
    settle();

    $display("checked %0d composited pixels from %0d requests (%0d composites)",
             pixels_checked, requests_seen, composites_seen);
    $display("over %0d register settings incl. hidden stack, zero and saturated screen sizes",
             setting_count);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+design
design/ckl_pkg.sv
design/ckl_channels.sv
design/ckl_ram.sv
design/color_keyed_layer_compositor.sv
tb/sv/testbench.sv
